@@ hdl/pld_pkg.sv @@
// Package for the point-to-line distance block.
// Default widths, fixed output widths and register codes; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package pld_pkg;

  localparam int COORD_BITS_DEF    = 24;
  localparam int FRACTION_BITS_DEF = 8;

  // result field and its byte-padded stream word
  localparam int OUT_BITS       = 33;
  localparam int OUT_TDATA_BITS = ((OUT_BITS + 7) / 8) * 8;

  // register select, paddr bit 2
  localparam logic REG_THREE_DIMENSIONAL = 1'b0;

  localparam int FIFO_DEPTH = 4;

endpackage

`default_nettype wire

@@ hdl/point_line_distance.sv @@
// Top level of the point-to-line distance block: APB register, front,
// queue and back. Uses pld_pkg, pld_front, pld_fifo and pld_back.
//
// Takes one input word per cycle while the queue has room and gives one
// result word per cycle while the output is taken, fully pipelined. A word
// that leaves the queue passes the product and sum stages, the
// one-bit-per-stage divider and square-root pipelines and the output
// register. The whole back pipeline advances only while its output register
// is empty or being taken; a four-word queue lets the input side keep
// accepting during short output stalls. The three_dimensional register must
// only be written while no word is in flight.
`timescale 1ns / 1ps
`default_nettype none

module point_line_distance
  import pld_pkg::*;
#(
  parameter int COORD_BITS    = COORD_BITS_DEF,
  parameter int FRACTION_BITS = FRACTION_BITS_DEF,
  parameter int IN_TW         = ((9 * COORD_BITS + 7) / 8) * 8
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  // point x,y,z, start x,y,z, end x,y,z, COORD_BITS each, zero padded
  input  wire logic [IN_TW-1:0]          s_axis_tdata,
  input  wire logic                      s_axis_tvalid,
  output logic                           s_axis_tready,
  // line_distance[32:0], zero padded
  output logic [OUT_TDATA_BITS-1:0]      m_axis_tdata,
  // degenerate_line
  output logic                           m_axis_tuser,
  output logic                           m_axis_tvalid,
  input  wire logic                      m_axis_tready,
  input  wire logic                      psel,
  input  wire logic                      penable,
  input  wire logic                      pwrite,
  input  wire logic [2:0]                paddr,
  input  wire logic [31:0]               pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready
);

  localparam int IN_W  = 9 * COORD_BITS;
  localparam int VEC_W = 6 * (COORD_BITS + 1) + 1;

  logic three_dim_q;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_THREE_DIMENSIONAL) ? {31'b0, three_dim_q} : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      three_dim_q <= 1'b0;
    end else if (psel && penable && pwrite && (paddr[2] == REG_THREE_DIMENSIONAL)) begin
      three_dim_q <= pwdata[0];
    end
  end

  logic             push, fifo_full, fifo_valid, fifo_pop;
  logic [VEC_W-1:0] push_data, fifo_data;
  logic [OUT_BITS-1:0] line_dist;

  pld_front #(
    .COORD_BITS (COORD_BITS),
    .IN_W       (IN_W),
    .VEC_W      (VEC_W)
  ) u_front (
    .s_tvalid_i  (s_axis_tvalid),
    .s_tready_o  (s_axis_tready),
    .s_tdata_i   (s_axis_tdata[IN_W-1:0]),
    .three_dim_i (three_dim_q),
    .fifo_full_i (fifo_full),
    .push_o      (push),
    .push_data_o (push_data)
  );

  pld_fifo #(
    .WIDTH (VEC_W),
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .full_o      (fifo_full),
    .pop_i       (fifo_pop),
    .valid_o     (fifo_valid),
    .data_o      (fifo_data)
  );

  pld_back #(
    .COORD_BITS    (COORD_BITS),
    .FRACTION_BITS (FRACTION_BITS),
    .VEC_W         (VEC_W)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .fifo_valid_i (fifo_valid),
    .fifo_data_i  (fifo_data),
    .fifo_pop_o   (fifo_pop),
    .m_tvalid_o   (m_axis_tvalid),
    .m_tready_i   (m_axis_tready),
    .dist_o       (line_dist),
    .degen_o      (m_axis_tuser)
  );

  assign m_axis_tdata = OUT_TDATA_BITS'(line_dist);

endmodule

`default_nettype wire

@@ hdl/pld_fifo.sv @@
// Short queue between the front and the back of the distance block.
// Generic register FIFO; uses nothing from the package.
`timescale 1ns / 1ps
`default_nettype none

module pld_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic [WIDTH-1:0] push_data_i,
  output logic                  full_o,
  input  wire logic             pop_i,
  output logic                  valid_o,
  output logic [WIDTH-1:0]      data_o
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PW-1:0]    wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CW-1:0]    count_q, count_d;
  logic             do_push, do_pop;

  assign full_o  = (count_q == CW'(DEPTH));
  assign valid_o = (count_q != '0);
  assign data_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (!do_push && do_pop) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

`default_nettype wire

@@ hdl/pld_front.sv @@
// Front of the distance block: takes input words, forms the difference
// vectors, applies the 2D/3D mode and flags a degenerate line. Uses pld_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pld_front
  import pld_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF,
  parameter int IN_W       = 9 * COORD_BITS,
  parameter int VEC_W      = 6 * (COORD_BITS + 1) + 1
) (
  input  wire logic            s_tvalid_i,
  output logic                 s_tready_o,
  input  wire logic [IN_W-1:0] s_tdata_i,
  input  wire logic            three_dim_i,
  input  wire logic            fifo_full_i,
  output logic                 push_o,
  output logic [VEC_W-1:0]     push_data_o
);

  localparam int D = COORD_BITS + 1;

  logic signed [COORD_BITS-1:0] fld [9];
  logic signed [D-1:0]          ax, ay, az, bx, by, bz;
  logic                         degen;

  for (genvar i = 0; i < 9; i++) begin : g_fld
    assign fld[i] = s_tdata_i[i*COORD_BITS +: COORD_BITS];
  end

  // fields: 0..2 point, 3..5 start, 6..8 end
  assign ax = D'(fld[0]) - D'(fld[3]);
  assign ay = D'(fld[1]) - D'(fld[4]);
  assign az = three_dim_i ? D'(fld[2]) - D'(fld[5]) : '0;
  assign bx = D'(fld[6]) - D'(fld[3]);
  assign by = D'(fld[7]) - D'(fld[4]);
  assign bz = three_dim_i ? D'(fld[8]) - D'(fld[5]) : '0;

  assign degen = (bx == '0) && (by == '0) && (bz == '0);

  assign s_tready_o  = !fifo_full_i;
  assign push_o      = s_tvalid_i && !fifo_full_i;
  assign push_data_o = {degen, bz, by, bx, az, ay, ax};

endmodule

`default_nettype wire

@@ hdl/pld_back.sv @@
// Back of the distance block: cross product, squared lengths, pipelined
// restoring division and square root, saturation. Uses pld_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pld_back
  import pld_pkg::*;
#(
  parameter int COORD_BITS    = COORD_BITS_DEF,
  parameter int FRACTION_BITS = FRACTION_BITS_DEF,
  parameter int VEC_W         = 6 * (COORD_BITS + 1) + 1
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             fifo_valid_i,
  input  wire logic [VEC_W-1:0] fifo_data_i,
  output logic                  fifo_pop_o,
  output logic                  m_tvalid_o,
  input  wire logic             m_tready_i,
  output logic [OUT_BITS-1:0]   dist_o,
  output logic                  degen_o
);

  localparam int D   = COORD_BITS + 1;
  localparam int MB  = 2 * D;
  localparam int H   = D;
  localparam int DB  = 2 * COORD_BITS + 2;
  localparam int C2B = 4 * COORD_BITS + 4;
  localparam int NB  = C2B + 2 * FRACTION_BITS;
  localparam int QB  = 2 * COORD_BITS + 2 * FRACTION_BITS + 2;
  localparam int SB  = QB / 2;

  logic en;
  assign en         = !m_tvalid_o || m_tready_i;
  assign fifo_pop_o = en && fifo_valid_i;

  logic signed [D-1:0] v [6];
  for (genvar i = 0; i < 6; i++) begin : g_vec
    assign v[i] = fifo_data_i[i*D +: D];
  end

  // stage 1: products
  logic                 s1_vld_q, s1_dg_q;
  logic signed [MB-1:0] s1_p_q [6];
  logic signed [MB-1:0] s1_sq_q [3];

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_p_q[0]  <= v[1] * v[5];
      s1_p_q[1]  <= v[2] * v[4];
      s1_p_q[2]  <= v[2] * v[3];
      s1_p_q[3]  <= v[0] * v[5];
      s1_p_q[4]  <= v[0] * v[4];
      s1_p_q[5]  <= v[1] * v[3];
      s1_sq_q[0] <= v[3] * v[3];
      s1_sq_q[1] <= v[4] * v[4];
      s1_sq_q[2] <= v[5] * v[5];
      s1_dg_q    <= fifo_data_i[VEC_W-1];
    end
  end

  // stage 2: cross components as magnitudes, squared line length
  logic signed [MB:0] cr [3];
  logic               s2_vld_q, s2_dg_q;
  logic [MB-1:0]      s2_mag_q [3];
  logic [DB-1:0]      s2_d2_q;

  for (genvar i = 0; i < 3; i++) begin : g_cross
    assign cr[i] = (MB+1)'(s1_p_q[2*i]) - (MB+1)'(s1_p_q[2*i+1]);
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        s2_mag_q[i] <= cr[i][MB] ? MB'(-cr[i]) : MB'(cr[i]);
      end
      s2_d2_q <= DB'($unsigned(s1_sq_q[0])) + DB'($unsigned(s1_sq_q[1]))
               + DB'($unsigned(s1_sq_q[2]));
      s2_dg_q <= s1_dg_q;
    end
  end

  // stage 3: half-word partial products of the squares
  logic          s3_vld_q, s3_dg_q;
  logic [MB-1:0] s3_hh_q [3], s3_hl_q [3], s3_ll_q [3];
  logic [DB-1:0] s3_d2_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        s3_hh_q[i] <= s2_mag_q[i][MB-1:H] * s2_mag_q[i][MB-1:H];
        s3_hl_q[i] <= s2_mag_q[i][MB-1:H] * s2_mag_q[i][H-1:0];
        s3_ll_q[i] <= s2_mag_q[i][H-1:0] * s2_mag_q[i][H-1:0];
      end
      s3_d2_q <= s2_d2_q;
      s3_dg_q <= s2_dg_q;
    end
  end

  // stage 4: per-component squares
  logic           s4_vld_q, s4_dg_q;
  logic [C2B-1:0] s4_sq_q [3];
  logic [DB-1:0]  s4_d2_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        s4_sq_q[i] <= (C2B'(s3_hh_q[i]) << (2 * H)) + (C2B'(s3_hl_q[i]) << (H + 1))
                    + C2B'(s3_ll_q[i]);
      end
      s4_d2_q <= s3_d2_q;
      s4_dg_q <= s3_dg_q;
    end
  end

  // stage 5: squared cross length
  logic           s5_vld_q, s5_dg_q;
  logic [C2B-1:0] s5_c2_q;
  logic [DB-1:0]  s5_d2_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      s5_c2_q <= s4_sq_q[0] + s4_sq_q[1] + s4_sq_q[2];
      s5_d2_q <= s4_d2_q;
      s5_dg_q <= s4_dg_q;
    end
  end

  // division c2 * 2^(2F) / d2, one quotient bit per stage
  logic [NB-1:0] num_full;
  logic [DB-1:0] dv_rem [QB+1];
  logic [QB-1:0] dv_num [QB+1];
  logic [DB-1:0] dv_den [QB+1];
  logic          dv_dg  [QB+1];
  logic          dv_vld [QB+1];

  assign num_full  = NB'(s5_c2_q) << (2 * FRACTION_BITS);
  assign dv_rem[0] = num_full[NB-1:QB];
  assign dv_num[0] = num_full[QB-1:0];
  assign dv_den[0] = s5_d2_q;
  assign dv_dg[0]  = s5_dg_q;
  assign dv_vld[0] = s5_vld_q;

  for (genvar k = 0; k < QB; k++) begin : g_div
    logic [DB:0] t;
    logic        ge;
    assign t  = {dv_rem[k], dv_num[k][QB-1]};
    assign ge = (t >= {1'b0, dv_den[k]});
    always_ff @(posedge clk_i) begin
      if (en) begin
        dv_rem[k+1] <= ge ? DB'(t - {1'b0, dv_den[k]}) : t[DB-1:0];
        dv_num[k+1] <= {dv_num[k][QB-2:0], ge};
        dv_den[k+1] <= dv_den[k];
        dv_dg[k+1]  <= dv_dg[k];
      end
    end
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dv_vld[k+1] <= 1'b0;
      end else if (en) begin
        dv_vld[k+1] <= dv_vld[k];
      end
    end
  end

  // integer square root of the quotient, one root bit per stage
  logic [SB+1:0] sq_rem  [SB+1];
  logic [SB-1:0] sq_root [SB+1];
  logic [QB-1:0] sq_num  [SB+1];
  logic          sq_dg   [SB+1];
  logic          sq_vld  [SB+1];

  assign sq_rem[0]  = '0;
  assign sq_root[0] = '0;
  assign sq_num[0]  = dv_num[QB];
  assign sq_dg[0]   = dv_dg[QB];
  assign sq_vld[0]  = dv_vld[QB];

  for (genvar k = 0; k < SB; k++) begin : g_sqrt
    logic [SB+1:0] t, trial;
    logic          ge;
    assign t     = {sq_rem[k][SB-1:0], sq_num[k][QB-1:QB-2]};
    assign trial = {sq_root[k], 2'b01};
    assign ge    = (t >= trial);
    always_ff @(posedge clk_i) begin
      if (en) begin
        sq_rem[k+1]  <= ge ? t - trial : t;
        sq_root[k+1] <= {sq_root[k][SB-2:0], ge};
        sq_num[k+1]  <= sq_num[k] << 2;
        sq_dg[k+1]   <= sq_dg[k];
      end
    end
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        sq_vld[k+1] <= 1'b0;
      end else if (en) begin
        sq_vld[k+1] <= sq_vld[k];
      end
    end
  end

  // saturation and output register
  logic [OUT_BITS-1:0] sat;

  if (SB > OUT_BITS) begin : g_sat
    assign sat = (|sq_root[SB][SB-1:OUT_BITS]) ? '1 : sq_root[SB][OUT_BITS-1:0];
  end else begin : g_nosat
    assign sat = OUT_BITS'(sq_root[SB]);
  end

  logic                out_vld_q, out_dg_q;
  logic [OUT_BITS-1:0] out_dist_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_dist_q <= sq_dg[SB] ? '0 : sat;
      out_dg_q   <= sq_dg[SB];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q  <= 1'b0;
      s2_vld_q  <= 1'b0;
      s3_vld_q  <= 1'b0;
      s4_vld_q  <= 1'b0;
      s5_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else if (en) begin
      s1_vld_q  <= fifo_valid_i;
      s2_vld_q  <= s1_vld_q;
      s3_vld_q  <= s2_vld_q;
      s4_vld_q  <= s3_vld_q;
      s5_vld_q  <= s4_vld_q;
      out_vld_q <= sq_vld[SB];
    end
  end

  assign m_tvalid_o = out_vld_q;
  assign dist_o     = out_dist_q;
  assign degen_o    = out_dg_q;

endmodule

`default_nettype wire

@@ hdl/pld_checker.sv @@
// Port-level assertions for point_line_distance, bound to the top level.
// Uses pld_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pld_checker
  import pld_pkg::*;
(
  input wire logic                      clk_i,
  input wire logic                      rst_ni,
  input wire logic [OUT_TDATA_BITS-1:0] m_tdata_i,
  input wire logic                      m_tuser_i,
  input wire logic                      m_tvalid_i,
  input wire logic                      m_tready_i,
  input wire logic                      psel_i,
  input wire logic                      penable_i,
  input wire logic                      pwrite_i,
  input wire logic [2:0]                paddr_i,
  input wire logic [31:0]               pwdata_i,
  input wire logic [31:0]               prdata_i
);

  a_reset_idle: assert property (@(posedge clk_i) !rst_ni |-> !m_tvalid_i)
    else $error("result word valid during reset");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_i && !m_tready_i |=> m_tvalid_i && $stable(m_tdata_i) && $stable(m_tuser_i))
    else $error("stalled result word changed");

  a_degen_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_i && m_tuser_i |-> m_tdata_i == '0)
    else $error("degenerate line with nonzero distance");

  a_reg_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    psel_i && penable_i && pwrite_i && (paddr_i[2] == REG_THREE_DIMENSIONAL)
    |=> (paddr_i[2] != REG_THREE_DIMENSIONAL) || (prdata_i == {31'b0, $past(pwdata_i[0])}))
    else $error("register readback mismatch");

endmodule

bind point_line_distance pld_checker u_pld_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .m_tdata_i  (m_axis_tdata),
  .m_tuser_i  (m_axis_tuser),
  .m_tvalid_i (m_axis_tvalid),
  .m_tready_i (m_axis_tready),
  .psel_i     (psel),
  .penable_i  (penable),
  .pwrite_i   (pwrite),
  .paddr_i    (paddr),
  .pwdata_i   (pwdata),
  .prdata_i   (prdata)
);

`default_nettype wire

@@ sim/tb.sv @@
// Testbench for point_line_distance: streams point/line words through the
// block and checks each result against an exact in-bench predictor.
// Depends on pld_pkg and the point_line_distance RTL.
`timescale 1ns / 1ps

module tb;
  import pld_pkg::*;

  localparam int CB = COORD_BITS_DEF;
  localparam int FB = FRACTION_BITS_DEF;
  localparam int IN_TW = ((9 * CB + 7) / 8) * 8;
  localparam int LATENCY = 140;
  localparam longint CYCLE_LIMIT = 600000;

  typedef logic signed [CB-1:0] coord_t;
  typedef struct packed {
    logic [OUT_BITS-1:0] line_distance;
    logic                degenerate_line;
  } dist_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b1;
  logic [IN_TW-1:0] s_axis_tdata = '0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [OUT_TDATA_BITS-1:0] m_axis_tdata;
  logic m_axis_tuser, m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  point_line_distance u_dut (.*);

  dist_t expected_dist_q[$];
  int errors = 0;
  bit mode_3d = 1'b0;
  bit hold_off = 1'b0;
  bit done = 1'b0;
  longint cycles = 0;

  initial forever #5 clk_i = ~clk_i;

  // exact floor(|cross| * 2^FB / |d|), integer square root by bisection
  function automatic dist_t predict_distance(input coord_t c[9]);
    logic signed [63:0] ax, ay, az, bx, by, bz, cx, cy, cz;
    logic [255:0] d2, c2, rhs, t, lhs;
    logic [OUT_BITS-1:0] r;
    dist_t res;
    ax = c[0] - c[3]; ay = c[1] - c[4];
    bx = c[6] - c[3]; by = c[7] - c[4];
    az = mode_3d ? c[2] - c[5] : 0;
    bz = mode_3d ? c[8] - c[5] : 0;
    d2 = 256'(bx * bx) + 256'(by * by) + 256'(bz * bz);
    res = '0;
    if (d2 == 0) begin
      res.degenerate_line = 1'b1;
      return res;
    end
    cx = ay * bz - az * by;
    cy = az * bx - ax * bz;
    cz = ax * by - ay * bx;
    c2 = 256'($unsigned(cx < 0 ? -cx : cx)) ** 2 + 256'($unsigned(cy < 0 ? -cy : cy)) ** 2
       + 256'($unsigned(cz < 0 ? -cz : cz)) ** 2;
    rhs = c2 << (2 * FB);
    r = '0;
    for (int b = OUT_BITS - 1; b >= 0; b--) begin
      t = 256'(r | (33'd1 << b));
      lhs = t * t * d2;
      if (lhs <= rhs) r = t[OUT_BITS-1:0];
    end
    res.line_distance = r;
    return res;
  endfunction

  task automatic idle_cycles(input int n);
    repeat (n) @(posedge clk_i);
  endtask

  function automatic int gap_len();
    int p;
    p = $urandom_range(0, 99);
    if (p < 55) return 0;
    if (p < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic send_word(input coord_t c[9], input bit gaps);
    logic [IN_TW-1:0] w;
    int n;
    w = '0;
    for (int i = 0; i < 9; i++) w[i*CB +: CB] = c[i];
    n = gaps ? gap_len() : 0;
    if (n > 0) begin
      s_axis_tvalid <= 1'b0;
      idle_cycles(n);
    end
    s_axis_tdata <= w;
    s_axis_tvalid <= 1'b1;
    expected_dist_q.push_back(predict_distance(c));
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (expected_dist_q.size() != 0) @(posedge clk_i);
    idle_cycles(LATENCY);
  endtask

  task automatic write_mode(input bit three);
    drain();
    psel <= 1'b1; pwrite <= 1'b1; paddr <= {REG_THREE_DIMENSIONAL, 2'b00};
    pwdata <= {$urandom_range(0, 1) ? 31'h7fffffff : 31'h0, three};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    mode_3d = three;
  endtask

  function automatic coord_t rand_coord(input int kind);
    case (kind)
      0: return coord_t'($urandom);
      1: return coord_t'(int'($urandom_range(0, 64)) - 32);
      2: return $urandom_range(0, 1) ? {1'b1, {(CB-1){1'b0}}} : {1'b0, {(CB-1){1'b1}}};
      default: return coord_t'(int'($urandom_range(0, 4095)) - 2048);
    endcase
  endfunction

  task automatic test_directed();
    coord_t c[9];
    coord_t mn, mx;
    mn = {1'b1, {(CB-1){1'b0}}};
    mx = {1'b0, {(CB-1){1'b1}}};
    c = '{0, 0, 0, 0, 0, 0, 0, 0, 0};         send_word(c, 0); // degenerate at origin
    c = '{5, 5, 9, 1, 1, 3, 1, 1, 7};         send_word(c, 0); // z differs only
    c = '{mx, mx, mx, mn, mn, mn, mx, mn, mx}; send_word(c, 0);
    c = '{mn, mx, mn, mx, mn, mx, mn, mx, mn}; send_word(c, 0);
    c = '{mn, mn, mn, mx, mx, mx, mn, mx, mn}; send_word(c, 0);
    c = '{3, 4, 0, 0, 0, 0, 1, 0, 0};         send_word(c, 0);
    c = '{1, 1, 1, 0, 0, 0, 1, 1, 1};         send_word(c, 0); // point on line
    c = '{mx, 0, 0, mn, 0, 0, mn, 1, 0};      send_word(c, 0);
    c = '{-1, -1, -1, -1, -1, -1, -1, -1, -1}; send_word(c, 0);
    c = '{7, -3, 2, 1, 2, 3, 1, 2, 4};        send_word(c, 0);
  endtask

  task automatic test_random(input int n);
    coord_t c[9];
    int kind;
    for (int k = 0; k < n; k++) begin
      kind = $urandom_range(0, 3);
      for (int i = 0; i < 9; i++) c[i] = rand_coord($urandom_range(0, 9) == 0 ? 2 : kind);
      if ($urandom_range(0, 19) == 0) begin
        c[6] = c[3]; c[7] = c[4];
        if ($urandom_range(0, 1)) c[8] = c[5];
      end
      send_word(c, 1);
    end
  endtask

  // enough words to fill the back pipeline and the queue
  task automatic test_backpressure();
    coord_t c[9];
    hold_off = 1'b1;
    for (int k = 0; k < 200; k++) begin
      for (int i = 0; i < 9; i++) c[i] = rand_coord(0);
      send_word(c, 0);
    end
    hold_off = 1'b0;
    drain();
  endtask

  // receiver ready: long stall counted in cycles under hold_off, random otherwise
  initial begin
    int stall;
    stall = 0;
    forever begin
      @(posedge clk_i);
      if (hold_off && stall < 400) begin
        m_axis_tready <= 1'b0;
        stall++;
      end else begin
        if (!hold_off) stall = 0;
        if ($urandom_range(0, 199) == 0) begin
          m_axis_tready <= 1'b0;
          idle_cycles($urandom_range(10, 40));
        end else begin
          m_axis_tready <= ($urandom_range(0, 99) < 70) ||
                           (stall >= 400 && $urandom_range(0, 1));
        end
      end
    end
  end

  always @(posedge clk_i) begin
    dist_t exp_d;
    if (m_axis_tvalid && m_axis_tready) begin
      if (expected_dist_q.size() == 0) begin
        $display("%0t: unexpected word dist=%0d degen=%0b", $time,
                 m_axis_tdata[OUT_BITS-1:0], m_axis_tuser);
        errors++;
      end else begin
        exp_d = expected_dist_q.pop_front();
        if (m_axis_tdata[OUT_BITS-1:0] !== exp_d.line_distance ||
            m_axis_tdata[OUT_TDATA_BITS-1:OUT_BITS] !== '0) begin
          $display("%0t: line_distance expected %0d actual %0d", $time,
                   exp_d.line_distance, m_axis_tdata);
          errors++;
        end
        if (m_axis_tuser !== exp_d.degenerate_line) begin
          $display("%0t: degenerate_line expected %0b actual %0b", $time,
                   exp_d.degenerate_line, m_axis_tuser);
          errors++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT && !done) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    rst_ni <= 1'b0;
    idle_cycles(5);
    rst_ni <= 1'b1;
    idle_cycles(2);
    test_directed();
    write_mode(1'b1);
    test_directed();
    test_random(300);
    test_backpressure();
    write_mode(1'b0);
    test_random(250);
    write_mode(1'b1);
    test_random(250);
    drain();
    done = 1'b1;
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
